// ===== design/fresnel_dielectric_reflectance_defines.svh =====
// Assertion macros shared by the Fresnel reflectance RTL.
`ifndef FRESNEL_DIELECTRIC_REFLECTANCE_DEFINES_SVH
`define FRESNEL_DIELECTRIC_REFLECTANCE_DEFINES_SVH

// Condition a implies condition b in the same cycle.
`define FDR_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("fdr implication check failed");

// Condition a implies condition b in the next cycle.
`define FDR_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("fdr next-cycle check failed");

`endif

// ===== design/fdr_pkg.sv =====
`default_nettype none
package fdr_pkg;

    localparam int unsigned ONE_Q15 = 32768;

    // configuration register indexes
    localparam logic CFG_INDEX_INCIDENT    = 1'b0;
    localparam logic CFG_INDEX_TRANSMITTED = 1'b1;

    localparam logic [15:0] INDEX_INCIDENT_RESET    = 16'd16384;
    localparam logic [15:0] INDEX_TRANSMITTED_RESET = 16'd24576;

    // restoring divider cell widths (shared by the divider chain and both ratio lanes)
    localparam int unsigned DIV_REM_W = 34;
    localparam int unsigned DIV_LO_W  = 33;
    localparam int unsigned DIV_Q_W   = 33;
    localparam int unsigned DIV_D_W   = 34;

    // square root cell widths
    localparam int unsigned SQ_REM_W  = 18;
    localparam int unsigned SQ_V_W    = 34;
    localparam int unsigned SQ_ROOT_W = 17;

    // chain lengths
    localparam int unsigned DIV1_STEPS = 33;
    localparam int unsigned SQRT_STEPS = 17;
    localparam int unsigned DIV2_STEPS = 17;

    typedef struct packed {
        logic        tir;
        logic [15:0] cos;
        logic [15:0] ei;
        logic [15:0] et;
    } side_t;

    typedef struct packed {
        logic [DIV_REM_W-1:0] rem;
        logic [DIV_LO_W-1:0]  lo;
        logic [DIV_Q_W-1:0]   q;
        logic [DIV_D_W-1:0]   d;
    } div_t;

    typedef struct packed {
        logic [SQ_REM_W-1:0]  rem;
        logic [SQ_V_W-1:0]    v;
        logic [SQ_ROOT_W-1:0] root;
    } sq_t;

endpackage
`default_nettype wire

// ===== design/fresnel_dielectric_reflectance.sv =====
// Throughput: one beat per cycle while the skid slot is empty, set by the fully
// pipelined cell chains (33-cell divider, 17-cell square root, two 17-cell
// divider lanes).
// An output register plus a one-beat skid absorbs the first stalled cycle;
// the input stalls for as long as the skid holds a beat.
// Reset (rst_n, async, active low) empties the pipeline; indices reset to 1.0 and 1.5.
`default_nettype none
`include "fresnel_dielectric_reflectance_defines.svh"
module fresnel_dielectric_reflectance (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic signed [15:0] incident_cosine,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [15:0]        reflectance,
    output logic               total_reflection,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int unsigned D1 = fdr_pkg::DIV1_STEPS;
    localparam int unsigned SQ = fdr_pkg::SQRT_STEPS;
    localparam int unsigned D2 = fdr_pkg::DIV2_STEPS;

    // configuration registers
    logic [15:0] index_incident_reg;
    logic [15:0] index_transmitted_reg;

    // the whole pipeline advances together while the skid slot is empty
    logic en;

    // stage A: magnitude and side swap
    logic        a_v_reg;
    logic [15:0] a_c_reg, a_ei_reg, a_et_reg;
    logic [15:0] raw, a_c_next;
    logic        negative;

    // stage B: squares
    logic        b_v_reg;
    logic [30:0] b_s2i_reg;
    logic [31:0] b_ei2_reg, b_et2_reg;
    fdr_pkg::side_t b_side_reg;
    logic [31:0] cc;

    // stage C: ei^2 * sin_i^2
    logic        c_v_reg;
    logic [61:0] c_lhs_reg;
    logic [31:0] c_et2_reg;
    fdr_pkg::side_t c_side_reg;

    // stage D: total internal reflection test and divider numerator
    logic        d_v_reg;
    logic [63:0] d_num_reg;
    logic [31:0] d_et2_reg;
    fdr_pkg::side_t d_side_reg;
    logic [61:0] rhs;
    logic [62:0] gap;
    logic        tir_next;

    // divider chain for cos_t^2
    logic           div1_v    [0:D1];
    fdr_pkg::side_t div1_side [0:D1];
    fdr_pkg::div_t  div1_dat  [0:D1];

    // square root chain for cos_t
    logic           sq_v    [0:SQ];
    fdr_pkg::side_t sq_side [0:SQ];
    fdr_pkg::sq_t   sq_dat  [0:SQ];

    // stage E: amplitude products
    logic        e_v_reg;
    logic        e_tir_reg;
    logic [32:0] e_xpar_reg, e_ypar_reg, e_xperp_reg, e_yperp_reg;
    logic [16:0] ci16;
    logic [16:0] ct16;
    fdr_pkg::side_t e_side;

    // stage F: sums and differences
    logic        f_v_reg;
    logic        f_tir_reg;
    logic [33:0] f_den_par_reg, f_den_perp_reg;
    logic [32:0] f_dif_par_reg, f_dif_perp_reg;

    // divider lanes for the two amplitude ratios
    logic           dpa_v    [0:D2];
    fdr_pkg::side_t dpa_side [0:D2];
    fdr_pkg::div_t  dpa_dat  [0:D2];
    logic           dpe_v    [0:D2];
    fdr_pkg::side_t dpe_side [0:D2];
    fdr_pkg::div_t  dpe_dat  [0:D2];
    fdr_pkg::side_t f_side;

    // stage G: squared ratios
    logic        g_v_reg;
    logic        g_tir_reg;
    logic [33:0] g_sq_par_reg, g_sq_perp_reg;
    logic [16:0] r_par, r_perp;

    // final rounding
    logic [34:0] sum;
    logic [16:0] refl17;
    logic [15:0] refl_final;
    logic        tir_final;

    // output register and skid slot
    logic        res_valid_reg, skid_valid_reg;
    logic [15:0] res_refl_reg, skid_refl_reg;
    logic        res_tir_reg, skid_tir_reg;

    assign en        = !skid_valid_reg;
    assign req_stall = skid_valid_reg;
    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_incident_reg    <= fdr_pkg::INDEX_INCIDENT_RESET;
            index_transmitted_reg <= fdr_pkg::INDEX_TRANSMITTED_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                fdr_pkg::CFG_INDEX_INCIDENT:    index_incident_reg    <= cfg_data;
                fdr_pkg::CFG_INDEX_TRANSMITTED: index_transmitted_reg <= cfg_data;
                default:                        index_incident_reg    <= index_incident_reg;
            endcase
        end
    end

    // stage A: a zero or negative cosine exits, so swap the indices
    always_comb
    begin
        raw      = incident_cosine;
        negative = raw[15];
        a_c_next = negative ? 16'(~raw + 16'd1) : raw;
    end

    // stage B
    assign cc = 32'(a_c_reg) * 32'(a_c_reg);

    // stage D: lhs >= rhs is total internal reflection, as is et == 0
    always_comb
    begin
        rhs      = {c_et2_reg[31:0], 30'b0};
        gap      = {1'b0, rhs} - {1'b0, c_lhs_reg};
        tir_next = gap[62] || (gap == 63'd0) || (c_side_reg.et == 16'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg <= req_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
            e_v_reg <= sq_v[SQ];
            f_v_reg <= e_v_reg;
            g_v_reg <= dpa_v[D2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_c_reg  <= a_c_next;
            a_ei_reg <= (negative || a_c_next == 16'd0) ? index_transmitted_reg
                                                       : index_incident_reg;
            a_et_reg <= (negative || a_c_next == 16'd0) ? index_incident_reg
                                                       : index_transmitted_reg;

            b_s2i_reg  <= 31'(32'h4000_0000 - cc);
            b_ei2_reg  <= 32'(a_ei_reg) * 32'(a_ei_reg);
            b_et2_reg  <= 32'(a_et_reg) * 32'(a_et_reg);
            b_side_reg <= '{tir: 1'b0, cos: a_c_reg, ei: a_ei_reg, et: a_et_reg};

            c_lhs_reg  <= 62'(64'(b_ei2_reg) * 64'(b_s2i_reg));
            c_et2_reg  <= b_et2_reg;
            c_side_reg <= b_side_reg;

            d_num_reg  <= {gap[61:0], 2'b00};
            d_et2_reg  <= c_et2_reg;
            d_side_reg <= '{tir: tir_next, cos: c_side_reg.cos,
                            ei: c_side_reg.ei, et: c_side_reg.et};
        end
    end

    // divider chain: cos_t^2 = 4 * (rhs - lhs) / et^2, quotient below 2^33
    assign div1_v[0]        = d_v_reg;
    assign div1_side[0]     = d_side_reg;
    assign div1_dat[0].rem  = fdr_pkg::DIV_REM_W'(d_num_reg[63:33]);
    assign div1_dat[0].lo   = d_num_reg[32:0];
    assign div1_dat[0].q    = '0;
    assign div1_dat[0].d    = fdr_pkg::DIV_D_W'(d_et2_reg);

    for (genvar i = 0; i < D1; i++)
    begin : g_div1
        fdr_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .v_in     (div1_v[i]),
            .side_in  (div1_side[i]),
            .dat_in   (div1_dat[i]),
            .v_out    (div1_v[i+1]),
            .side_out (div1_side[i+1]),
            .dat_out  (div1_dat[i+1])
        );
    end

    // square root chain
    assign sq_v[0]        = div1_v[D1];
    assign sq_side[0]     = div1_side[D1];
    assign sq_dat[0].rem  = '0;
    assign sq_dat[0].v    = fdr_pkg::SQ_V_W'(div1_dat[D1].q);
    assign sq_dat[0].root = '0;

    for (genvar i = 0; i < SQ; i++)
    begin : g_sqrt
        fdr_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .v_in     (sq_v[i]),
            .side_in  (sq_side[i]),
            .dat_in   (sq_dat[i]),
            .v_out    (sq_v[i+1]),
            .side_out (sq_side[i+1]),
            .dat_out  (sq_dat[i+1])
        );
    end

    // stage E / F
    assign e_side = sq_side[SQ];
    assign ci16   = {e_side.cos, 1'b0};
    assign ct16   = sq_dat[SQ].root;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_tir_reg   <= e_side.tir;
            e_xpar_reg  <= 33'(e_side.et) * 33'(ci16);
            e_ypar_reg  <= 33'(e_side.ei) * 33'(ct16);
            e_xperp_reg <= 33'(e_side.ei) * 33'(ci16);
            e_yperp_reg <= 33'(e_side.et) * 33'(ct16);

            f_tir_reg      <= e_tir_reg;
            f_den_par_reg  <= 34'(e_xpar_reg) + 34'(e_ypar_reg);
            f_den_perp_reg <= 34'(e_xperp_reg) + 34'(e_yperp_reg);
            f_dif_par_reg  <= (e_xpar_reg >= e_ypar_reg) ? e_xpar_reg - e_ypar_reg
                                                         : e_ypar_reg - e_xpar_reg;
            f_dif_perp_reg <= (e_xperp_reg >= e_yperp_reg) ? e_xperp_reg - e_yperp_reg
                                                           : e_yperp_reg - e_xperp_reg;
        end
    end

    // ratio lanes: (diff << 16) / den, quotient at most 2^16
    assign f_side = '{tir: f_tir_reg, cos: 16'd0, ei: 16'd0, et: 16'd0};

    assign dpa_v[0]       = f_v_reg;
    assign dpa_side[0]    = f_side;
    assign dpa_dat[0].rem = fdr_pkg::DIV_REM_W'(f_dif_par_reg[32:1]);
    assign dpa_dat[0].lo  = {f_dif_par_reg[0], 32'b0};
    assign dpa_dat[0].q   = '0;
    assign dpa_dat[0].d   = f_den_par_reg;

    assign dpe_v[0]       = f_v_reg;
    assign dpe_side[0]    = f_side;
    assign dpe_dat[0].rem = fdr_pkg::DIV_REM_W'(f_dif_perp_reg[32:1]);
    assign dpe_dat[0].lo  = {f_dif_perp_reg[0], 32'b0};
    assign dpe_dat[0].q   = '0;
    assign dpe_dat[0].d   = f_den_perp_reg;

    for (genvar i = 0; i < D2; i++)
    begin : g_div2
        fdr_div_cell u_par (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .v_in     (dpa_v[i]),
            .side_in  (dpa_side[i]),
            .dat_in   (dpa_dat[i]),
            .v_out    (dpa_v[i+1]),
            .side_out (dpa_side[i+1]),
            .dat_out  (dpa_dat[i+1])
        );
        fdr_div_cell u_perp (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .v_in     (dpe_v[i]),
            .side_in  (dpe_side[i]),
            .dat_in   (dpe_dat[i]),
            .v_out    (dpe_v[i+1]),
            .side_out (dpe_side[i+1]),
            .dat_out  (dpe_dat[i+1])
        );
    end

    // stage G: a vanishing denominator takes the grazing limit of 1.0
    assign r_par  = (dpa_dat[D2].d == '0) ? 17'h10000 : dpa_dat[D2].q[16:0];
    assign r_perp = (dpe_dat[D2].d == '0) ? 17'h10000 : dpe_dat[D2].q[16:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_tir_reg     <= dpa_side[D2].tir | dpe_side[D2].tir;
            g_sq_par_reg  <= 34'(r_par) * 34'(r_par);
            g_sq_perp_reg <= 34'(r_perp) * 34'(r_perp);
        end
    end

    // average to Q1.15 with round half up, then saturate at 1.0; total reflection gives 1.0
    always_comb
    begin
        sum    = 35'(g_sq_par_reg) + 35'(g_sq_perp_reg) + 35'(32'h0002_0000);
        refl17 = sum[34:18];
        if (g_tir_reg)
        begin
            refl_final = 16'(fdr_pkg::ONE_Q15);
            tir_final  = 1'b1;
        end
        else
        begin
            refl_final = (refl17 > 17'(fdr_pkg::ONE_Q15)) ? 16'(fdr_pkg::ONE_Q15)
                                                          : refl17[15:0];
            tir_final  = 1'b0;
        end
    end

    // output register with skid slot; a fresh beat parks in the skid when
    // the held result is stalled, and the pipeline holds while it is full
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!en)
        begin
            if (!res_stall)
            begin
                res_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (g_v_reg)
        begin
            if (res_valid_reg && res_stall)
                skid_valid_reg <= 1'b1;
            else
                res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!en)
        begin
            if (!res_stall)
            begin
                res_refl_reg <= skid_refl_reg;
                res_tir_reg  <= skid_tir_reg;
            end
        end
        else if (g_v_reg)
        begin
            if (res_valid_reg && res_stall)
            begin
                skid_refl_reg <= refl_final;
                skid_tir_reg  <= tir_final;
            end
            else
            begin
                res_refl_reg <= refl_final;
                res_tir_reg  <= tir_final;
            end
        end
    end

    assign res_valid        = res_valid_reg;
    assign reflectance      = res_refl_reg;
    assign total_reflection = res_tir_reg;

    `FDR_ASSERT_IMPLY(a_tir_is_one, clk, rst_n, res_valid && total_reflection,
                      reflectance == 16'(fdr_pkg::ONE_Q15))
    `FDR_ASSERT_IMPLY(a_refl_range, clk, rst_n, res_valid,
                      reflectance <= 16'(fdr_pkg::ONE_Q15))
    `FDR_ASSERT_IMPLY(a_skid_needs_out, clk, rst_n, skid_valid_reg, res_valid_reg)
    `FDR_ASSERT_IMPLY(a_lanes_aligned, clk, rst_n, 1'b1, dpa_v[D2] == dpe_v[D2])
    `FDR_ASSERT_NEXT(a_hold_pipe, clk, rst_n, !en && res_stall, $stable(g_v_reg))

endmodule
`default_nettype wire

// ===== design/fdr_div_cell.sv =====
`default_nettype none
// One restoring division step: shift in a dividend bit, subtract if it fits.
module fdr_div_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           v_in,
    input  fdr_pkg::side_t side_in,
    input  fdr_pkg::div_t  dat_in,
    output logic           v_out,
    output fdr_pkg::side_t side_out,
    output fdr_pkg::div_t  dat_out
);

    logic                      v_reg;
    fdr_pkg::side_t            side_reg;
    fdr_pkg::div_t             dat_reg;
    fdr_pkg::div_t             dat_next;
    logic [fdr_pkg::DIV_REM_W:0] trial;
    logic [fdr_pkg::DIV_REM_W:0] dext;

    always_comb
    begin
        trial    = {dat_in.rem, dat_in.lo[fdr_pkg::DIV_LO_W-1]};
        dext     = {1'b0, dat_in.d};
        dat_next = dat_in;
        dat_next.lo = {dat_in.lo[fdr_pkg::DIV_LO_W-2:0], 1'b0};
        if (trial >= dext)
        begin
            dat_next.rem = fdr_pkg::DIV_REM_W'(trial - dext);
            dat_next.q   = {dat_in.q[fdr_pkg::DIV_Q_W-2:0], 1'b1};
        end
        else
        begin
            dat_next.rem = trial[fdr_pkg::DIV_REM_W-1:0];
            dat_next.q   = {dat_in.q[fdr_pkg::DIV_Q_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= v_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_in;
            dat_reg  <= dat_next;
        end
    end

    assign v_out    = v_reg;
    assign side_out = side_reg;
    assign dat_out  = dat_reg;

endmodule
`default_nettype wire

// ===== design/fdr_sqrt_cell.sv =====
`default_nettype none
// One digit of the bitwise integer square root: bring down two bits, try 4r+1.
module fdr_sqrt_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           v_in,
    input  fdr_pkg::side_t side_in,
    input  fdr_pkg::sq_t   dat_in,
    output logic           v_out,
    output fdr_pkg::side_t side_out,
    output fdr_pkg::sq_t   dat_out
);

    logic                          v_reg;
    fdr_pkg::side_t                side_reg;
    fdr_pkg::sq_t                  dat_reg;
    fdr_pkg::sq_t                  dat_next;
    logic [fdr_pkg::SQ_REM_W+1:0]  t;
    logic [fdr_pkg::SQ_REM_W+1:0]  trial;

    always_comb
    begin
        t        = {dat_in.rem, dat_in.v[fdr_pkg::SQ_V_W-1 -: 2]};
        trial    = (fdr_pkg::SQ_REM_W+2)'({dat_in.root, 2'b01});
        dat_next = dat_in;
        dat_next.v = {dat_in.v[fdr_pkg::SQ_V_W-3:0], 2'b00};
        if (t >= trial)
        begin
            dat_next.rem  = fdr_pkg::SQ_REM_W'(t - trial);
            dat_next.root = {dat_in.root[fdr_pkg::SQ_ROOT_W-2:0], 1'b1};
        end
        else
        begin
            dat_next.rem  = t[fdr_pkg::SQ_REM_W-1:0];
            dat_next.root = {dat_in.root[fdr_pkg::SQ_ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= v_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_in;
            dat_reg  <= dat_next;
        end
    end

    assign v_out    = v_reg;
    assign side_out = side_reg;
    assign dat_out  = dat_reg;

endmodule
`default_nettype wire
